// ===== src/xxh64_pkg.sv =====
// Package with the XXH64 constants, sequencer types and rotate helper.
package xxh64_pkg;

    localparam logic [63:0] P1  = 64'd11400714785074694791;
    localparam logic [63:0] P2  = 64'd14029467366897019727;
    localparam logic [63:0] P3  = 64'd1609587929392839161;
    localparam logic [63:0] P4  = 64'd9650029242287828579;
    localparam logic [63:0] P5  = 64'd2870177450012600261;
    localparam logic [63:0] P12 = P1 + P2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MIX_MUL1,
        ST_MIX_ROT,
        ST_MIX_MUL2,
        ST_MIX_DONE,
        ST_POST_MUL,
        ST_POST_ADD,
        ST_FIN_BEGIN,
        ST_SUM,
        ST_LEN,
        ST_FOLD_SEL,
        ST_TAIL4_MUL1,
        ST_TAIL4_ROT,
        ST_TAIL4_MUL2,
        ST_TAIL4_ADD,
        ST_BYTE_SEL,
        ST_BYTE_MUL1,
        ST_BYTE_ROT,
        ST_BYTE_MUL2,
        ST_BYTE_DONE,
        ST_AV_PREP,
        ST_AV_MUL1,
        ST_AV_XOR,
        ST_AV_MUL2,
        ST_AV_OUT
    } t_state;

    typedef enum logic [1:0] {
        STG_STRIPE,
        STG_MERGE,
        STG_FOLD_BUF,
        STG_FOLD_WORD
    } t_stage;

    function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
        return (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

// ===== src/xxhash64_stream_hasher_top.sv =====
// XXH64 stream hasher built around one shared 32x32 multiplier and a sequencer.
//
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_stall      i_data_word, i_byte_count, i_last
// out      output     o_out_valid / i_out_stall    o_hash
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_seed
//
// A word that only fills the stripe buffer is stored there without leaving the idle state.
// A word that completes a stripe runs a round for each of the four lanes.
// The last word then goes through the merge, the buffered words and the tail bytes;
// each 64-bit product is built from three partial products of the 32x32 unit.
// Reset is synchronous and active low; the stripe buffer is not cleared.
// A finished hash waits in the output register while a new message is taken.
module xxhash64_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_seed
);

    xxh64_pkg::t_state r_state, n_state;
    xxh64_pkg::t_stage r_stage, n_stage;

    logic [63:0] r_seed;
    logic [63:0] r_lane [4];
    logic [63:0] n_lane [4];
    logic [63:0] r_buf  [4];
    logic [63:0] n_buf  [4];
    logic [1:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic        r_seen, n_seen;
    logic [63:0] r_word, n_word;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic [1:0]  r_idx, n_idx;
    logic [3:0]  r_bi, n_bi;
    logic [63:0] r_h, n_h;
    logic [63:0] r_t, n_t;
    logic [63:0] r_prod, n_prod;
    logic [1:0]  r_ph, n_ph;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_hash, n_hash;

    logic        in_fire;
    logic        out_free;
    logic [3:0]  in_cnt;
    logic        is_mul;
    logic        mul_end;
    logic [63:0] mul_b;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [1:0]  idx_inc;
    logic [63:0] sum_term;
    logic [63:0] av_out;
    logic [7:0]  tail_byte;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != xxh64_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_hash      = r_hash;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign in_cnt   = (!i_last || (i_byte_count > 4'd8)) ? 4'd8 : i_byte_count;
    assign idx_inc  = r_idx + 2'd1;
    assign mul_end  = (r_ph == 2'd2);
    assign av_out   = r_prod ^ (r_prod >> 32);
    assign tail_byte = 8'(r_word >> {r_bi[2:0], 3'b000});

    always_comb begin
        unique case (r_state) inside
            xxh64_pkg::ST_MIX_MUL1, xxh64_pkg::ST_TAIL4_MUL2, xxh64_pkg::ST_AV_MUL1: begin
                mul_b = xxh64_pkg::P2;
                is_mul = 1'b1;
            end
            xxh64_pkg::ST_MIX_MUL2, xxh64_pkg::ST_POST_MUL, xxh64_pkg::ST_TAIL4_MUL1,
            xxh64_pkg::ST_BYTE_MUL2: begin
                mul_b = xxh64_pkg::P1;
                is_mul = 1'b1;
            end
            xxh64_pkg::ST_BYTE_MUL1: begin
                mul_b = xxh64_pkg::P5;
                is_mul = 1'b1;
            end
            xxh64_pkg::ST_AV_MUL2: begin
                mul_b = xxh64_pkg::P3;
                is_mul = 1'b1;
            end
            default: begin
                mul_b = xxh64_pkg::P1;
                is_mul = 1'b0;
            end
        endcase
    end

    // The low 64 bits of the product are built from three 32x32 partial products.
    assign mul_x = (r_ph == 2'd2) ? r_t[63:32] : r_t[31:0];
    assign mul_y = (r_ph == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb begin
        case (r_idx)
            2'd0:    sum_term = xxh64_pkg::rotl(r_lane[0], 6'd1);
            2'd1:    sum_term = xxh64_pkg::rotl(r_lane[1], 6'd7);
            2'd2:    sum_term = xxh64_pkg::rotl(r_lane[2], 6'd12);
            default: sum_term = xxh64_pkg::rotl(r_lane[3], 6'd18);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xxh64_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if ((in_cnt == 4'd8) && (r_fill == 2'd3)) begin
                        n_state = xxh64_pkg::ST_MIX_MUL1;
                    end else if (i_last) begin
                        n_state = xxh64_pkg::ST_FIN_BEGIN;
                    end
                end
            end
            xxh64_pkg::ST_MIX_MUL1: if (mul_end) n_state = xxh64_pkg::ST_MIX_ROT;
            xxh64_pkg::ST_MIX_ROT: n_state = xxh64_pkg::ST_MIX_MUL2;
            xxh64_pkg::ST_MIX_MUL2: if (mul_end) n_state = xxh64_pkg::ST_MIX_DONE;
            xxh64_pkg::ST_MIX_DONE: begin
                if (r_stage == xxh64_pkg::STG_STRIPE) begin
                    if (r_idx != 2'd3) begin
                        n_state = xxh64_pkg::ST_MIX_MUL1;
                    end else if (r_last) begin
                        n_state = xxh64_pkg::ST_FIN_BEGIN;
                    end else begin
                        n_state = xxh64_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = xxh64_pkg::ST_POST_MUL;
                end
            end
            xxh64_pkg::ST_POST_MUL: if (mul_end) n_state = xxh64_pkg::ST_POST_ADD;
            xxh64_pkg::ST_POST_ADD: begin
                case (r_stage)
                    xxh64_pkg::STG_MERGE: begin
                        n_state = (r_idx == 2'd3) ? xxh64_pkg::ST_LEN : xxh64_pkg::ST_MIX_MUL1;
                    end
                    xxh64_pkg::STG_FOLD_BUF:  n_state = xxh64_pkg::ST_FOLD_SEL;
                    xxh64_pkg::STG_FOLD_WORD: n_state = xxh64_pkg::ST_AV_PREP;
                    default:                  n_state = xxh64_pkg::ST_IDLE;
                endcase
            end
            xxh64_pkg::ST_FIN_BEGIN: begin
                n_state = r_seen ? xxh64_pkg::ST_SUM : xxh64_pkg::ST_LEN;
            end
            xxh64_pkg::ST_SUM: if (r_idx == 2'd3) n_state = xxh64_pkg::ST_MIX_MUL1;
            xxh64_pkg::ST_LEN: n_state = xxh64_pkg::ST_FOLD_SEL;
            xxh64_pkg::ST_FOLD_SEL: begin
                if ((r_idx < r_fill) || (r_cnt == 4'd8)) begin
                    n_state = xxh64_pkg::ST_MIX_MUL1;
                end else if (r_cnt >= 4'd4) begin
                    n_state = xxh64_pkg::ST_TAIL4_MUL1;
                end else begin
                    n_state = xxh64_pkg::ST_BYTE_SEL;
                end
            end
            xxh64_pkg::ST_TAIL4_MUL1: if (mul_end) n_state = xxh64_pkg::ST_TAIL4_ROT;
            xxh64_pkg::ST_TAIL4_ROT: n_state = xxh64_pkg::ST_TAIL4_MUL2;
            xxh64_pkg::ST_TAIL4_MUL2: if (mul_end) n_state = xxh64_pkg::ST_TAIL4_ADD;
            xxh64_pkg::ST_TAIL4_ADD: n_state = xxh64_pkg::ST_BYTE_SEL;
            xxh64_pkg::ST_BYTE_SEL: begin
                n_state = (r_bi < r_cnt) ? xxh64_pkg::ST_BYTE_MUL1 : xxh64_pkg::ST_AV_PREP;
            end
            xxh64_pkg::ST_BYTE_MUL1: if (mul_end) n_state = xxh64_pkg::ST_BYTE_ROT;
            xxh64_pkg::ST_BYTE_ROT: n_state = xxh64_pkg::ST_BYTE_MUL2;
            xxh64_pkg::ST_BYTE_MUL2: if (mul_end) n_state = xxh64_pkg::ST_BYTE_DONE;
            xxh64_pkg::ST_BYTE_DONE: n_state = xxh64_pkg::ST_BYTE_SEL;
            xxh64_pkg::ST_AV_PREP: n_state = xxh64_pkg::ST_AV_MUL1;
            xxh64_pkg::ST_AV_MUL1: if (mul_end) n_state = xxh64_pkg::ST_AV_XOR;
            xxh64_pkg::ST_AV_XOR: n_state = xxh64_pkg::ST_AV_MUL2;
            xxh64_pkg::ST_AV_MUL2: if (mul_end) n_state = xxh64_pkg::ST_AV_OUT;
            xxh64_pkg::ST_AV_OUT: if (out_free) n_state = xxh64_pkg::ST_IDLE;
            default: n_state = xxh64_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_stage  = r_stage;
        n_lane   = r_lane;
        n_buf    = r_buf;
        n_fill   = r_fill;
        n_len    = r_len;
        n_seen   = r_seen;
        n_word   = r_word;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_idx    = r_idx;
        n_bi     = r_bi;
        n_h      = r_h;
        n_t      = r_t;
        n_prod   = r_prod;
        n_ph     = r_ph;
        n_hash   = r_hash;
        n_ovalid = r_ovalid;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (is_mul) begin
            n_ph = mul_end ? 2'd0 : r_ph + 2'd1;
            if (r_ph == 2'd0) begin
                n_prod = mul_p;
            end else begin
                n_prod = r_prod + {mul_p[31:0], 32'd0};
            end
        end

        unique case (r_state)
            xxh64_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_word = i_data_word;
                    n_cnt  = in_cnt;
                    n_last = i_last;
                    n_len  = r_len + {60'd0, in_cnt};
                    if ((r_len == 64'd0) && (r_fill == 2'd0) && !r_seen) begin
                        n_lane[0] = r_seed + xxh64_pkg::P12;
                        n_lane[1] = r_seed + xxh64_pkg::P2;
                        n_lane[2] = r_seed;
                        n_lane[3] = r_seed - xxh64_pkg::P1;
                    end
                    if ((in_cnt == 4'd8) && (r_fill == 2'd3)) begin
                        n_idx   = 2'd0;
                        n_t     = r_buf[0];
                        n_stage = xxh64_pkg::STG_STRIPE;
                    end else if (!i_last) begin
                        n_buf[r_fill] = i_data_word;
                        n_fill        = r_fill + 2'd1;
                    end
                end
            end
            xxh64_pkg::ST_MIX_ROT: begin
                if (r_stage == xxh64_pkg::STG_STRIPE) begin
                    n_t = xxh64_pkg::rotl(r_lane[r_idx] + r_prod, 6'd31);
                end else begin
                    n_t = xxh64_pkg::rotl(r_prod, 6'd31);
                end
            end
            xxh64_pkg::ST_MIX_DONE: begin
                case (r_stage)
                    xxh64_pkg::STG_STRIPE: begin
                        n_lane[r_idx] = r_prod;
                        if (r_idx == 2'd3) begin
                            n_fill = 2'd0;
                            n_seen = 1'b1;
                            n_cnt  = 4'd0;
                        end else begin
                            n_idx = idx_inc;
                            n_t   = (r_idx == 2'd2) ? r_word : r_buf[idx_inc];
                        end
                    end
                    xxh64_pkg::STG_MERGE: n_t = r_h ^ r_prod;
                    default: n_t = xxh64_pkg::rotl(r_h ^ r_prod, 6'd27);
                endcase
            end
            xxh64_pkg::ST_POST_ADD: begin
                n_h = r_prod + xxh64_pkg::P4;
                if (r_stage == xxh64_pkg::STG_MERGE) begin
                    n_idx = idx_inc;
                    n_t   = r_lane[idx_inc];
                    if (r_idx == 2'd3) begin
                        n_idx = 2'd0;
                    end
                end else if (r_stage == xxh64_pkg::STG_FOLD_BUF) begin
                    n_idx = idx_inc;
                end
            end
            xxh64_pkg::ST_FIN_BEGIN: begin
                n_idx = 2'd0;
                if (!r_seen) begin
                    n_h = r_seed + xxh64_pkg::P5;
                end
            end
            xxh64_pkg::ST_SUM: begin
                n_h = ((r_idx == 2'd0) ? 64'd0 : r_h) + sum_term;
                if (r_idx == 2'd3) begin
                    n_idx   = 2'd0;
                    n_t     = r_lane[0];
                    n_stage = xxh64_pkg::STG_MERGE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            xxh64_pkg::ST_LEN: begin
                n_h   = r_h + r_len;
                n_idx = 2'd0;
            end
            xxh64_pkg::ST_FOLD_SEL: begin
                if (r_idx < r_fill) begin
                    n_t     = r_buf[r_idx];
                    n_stage = xxh64_pkg::STG_FOLD_BUF;
                end else if (r_cnt == 4'd8) begin
                    n_t     = r_word;
                    n_stage = xxh64_pkg::STG_FOLD_WORD;
                end else if (r_cnt >= 4'd4) begin
                    n_t  = {32'd0, r_word[31:0]};
                    n_bi = 4'd4;
                end else begin
                    n_bi = 4'd0;
                end
            end
            xxh64_pkg::ST_TAIL4_ROT: n_t = xxh64_pkg::rotl(r_h ^ r_prod, 6'd23);
            xxh64_pkg::ST_TAIL4_ADD: n_h = r_prod + xxh64_pkg::P3;
            xxh64_pkg::ST_BYTE_SEL: begin
                if (r_bi < r_cnt) begin
                    n_t = {56'd0, tail_byte};
                end
            end
            xxh64_pkg::ST_BYTE_ROT: n_t = xxh64_pkg::rotl(r_h ^ r_prod, 6'd11);
            xxh64_pkg::ST_BYTE_DONE: begin
                n_h  = r_prod;
                n_bi = r_bi + 4'd1;
            end
            xxh64_pkg::ST_AV_PREP: n_t = r_h ^ (r_h >> 33);
            xxh64_pkg::ST_AV_XOR: n_t = r_prod ^ (r_prod >> 29);
            xxh64_pkg::ST_AV_OUT: begin
                if (out_free) begin
                    n_hash   = av_out;
                    n_ovalid = 1'b1;
                    n_fill   = 2'd0;
                    n_len    = 64'd0;
                    n_seen   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= xxh64_pkg::ST_IDLE;
            r_stage  <= xxh64_pkg::STG_STRIPE;
            r_seed   <= 64'd0;
            r_fill   <= 2'd0;
            r_len    <= 64'd0;
            r_seen   <= 1'b0;
            r_idx    <= 2'd0;
            r_bi     <= 4'd0;
            r_ph     <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stage  <= n_stage;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_idx    <= n_idx;
            r_bi     <= n_bi;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_buf  <= n_buf;
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_h    <= n_h;
        r_t    <= n_t;
        r_prod <= n_prod;
        r_hash <= n_hash;
    end

endmodule
